>>> rtl/core/bpa_pkg.sv
package bpa_pkg;

  // Region geometry. FRAME_COUNT is a power of two and a multiple of the
  // top-order block size.
  localparam int FRAME_COUNT = 4096;
  localparam int TOP_ORDER   = 10;
  localparam int FRAME_SHIFT = 12;

  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int LINK_W      = FRAME_W + 1;
  localparam int HIDX_W      = $clog2(TOP_ORDER + 1);
  localparam int ORDF_W      = 5;
  localparam int OUT_ORD_W   = 4;

  localparam logic [LINK_W-1:0] NIL_LINK    = LINK_W'(FRAME_COUNT);
  localparam logic [LINK_W-1:0] TOP_BLOCK   = LINK_W'(1) << TOP_ORDER;
  localparam logic [ORDF_W-1:0] MERGED_MARK = 5'd31;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TOO_BIG  = 2'd1;
  localparam logic [1:0] STAT_NO_BLOCK = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE = 2'd3;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;

  // One word of the frame store.
  typedef struct packed {
    logic              alloc;
    logic [ORDF_W-1:0] order;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } entry_t;

  // Contents of one frame after reset: top-order heads chained in
  // descending frame order, every other frame merged.
  function automatic entry_t reset_entry(logic [FRAME_W-1:0] k);
    entry_t            e;
    logic [LINK_W-1:0] kk;
    kk      = {1'b0, k};
    e.alloc = 1'b0;
    e.order = MERGED_MARK;
    e.next  = NIL_LINK;
    e.prev  = NIL_LINK;
    if ((kk & (TOP_BLOCK - LINK_W'(1))) == '0) begin
      e.order = ORDF_W'(TOP_ORDER);
      e.next  = (kk == '0) ? NIL_LINK : kk - TOP_BLOCK;
      e.prev  = (kk + TOP_BLOCK >= NIL_LINK) ? NIL_LINK : kk + TOP_BLOCK;
    end
    return e;
  endfunction

endpackage

>>> rtl/core/buddy_page_allocator_unit.sv
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_ready    req_type, alloc_size, free_address
// out       output     out_valid / out_ready  block_address, block_order, status
// cfg       input      APB psel/penable       region_base at byte address 0
//
// An allocation runs one split pass per level above the target order and then a
// pop; a free runs one merge pass per level; errors skip the list work. The
// frame store has one read and one write port, and a step may use both.
// After reset a clearing pass over all FRAME_COUNT frames builds the initial free lists
// while in_ready is low. A finished word waits in the output register; the next
// request is taken meanwhile, and a result only stalls the sequencer when that
// register is full.
module buddy_page_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [22:0] alloc_size,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] block_address,
  output logic [3:0]  block_order,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW = bpa_pkg::FRAME_W;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int HW = bpa_pkg::HIDX_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ALLOC,
    S_SP_CHK, S_SP_RD_F, S_SP_RD_N, S_SP_WR_N, S_SP_WR_H, S_SP_WR_B, S_SP_WR_F,
    S_PO_CHK, S_PO_RD_F, S_PO_RD_N, S_PO_WR_N,
    S_FR_RD, S_FR_CHK, S_ME_CHK, S_ME_RD_B, S_ME_EV, S_ME_WP, S_ME_WN, S_ME_WL,
    S_FR_PUSH, S_FR_WH, S_DONE
  } state_t;

  state_t                state;
  logic [FW-1:0]         clr_idx;
  logic [22:0]           req_size;
  logic [31:0]           region_base;
  logic [FW-1:0]         f;
  logic [FW-1:0]         buddy;
  logic [HW-1:0]         fo;
  logic [HW-1:0]         target;
  logic [HW-1:0]         ord;
  logic [HW-1:0]         first_ord;
  logic [LW-1:0]         nlink;
  logic [LW-1:0]         plink;
  logic [LW-1:0]         hlink;
  logic [LW-1:0]         heads [bpa_pkg::TOP_ORDER+1];
  logic [31:0]           res_addr;
  logic [3:0]            res_order;
  logic [1:0]            res_status;

  // Frame store.
  bpa_pkg::entry_t       mem [bpa_pkg::FRAME_COUNT];
  bpa_pkg::entry_t       rdata;
  bpa_pkg::entry_t       wdata;
  logic                  ren;
  logic                  wen;
  logic [FW-1:0]         raddr;
  logic [FW-1:0]         waddr;

  // Combinational helpers.
  logic [HW-1:0]         hidx;
  logic [LW-1:0]         head_rd;
  logic [HW-1:0]         tgt;
  logic                  too_big;
  logic                  found;
  logic [HW-1:0]         fo_sel;
  logic [31:0]           off;
  logic                  bad_range;
  logic [LW-1:0]         split_buddy;
  logic [LW-1:0]         merge_buddy;

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? region_base : 32'd0;

  // Head read mux used by the sequencer steps.
  always_comb begin
    case (state)
      S_SP_CHK:  hidx = fo;
      S_SP_WR_N: hidx = fo - HW'(1);
      S_PO_CHK:  hidx = target;
      default:   hidx = ord;
    endcase
  end
  assign head_rd = heads[hidx];

  // Target order and the smallest non-empty list that can serve it.
  always_comb begin
    tgt     = HW'(bpa_pkg::TOP_ORDER);
    too_big = 64'(req_size) > (64'd1 << (bpa_pkg::FRAME_SHIFT + bpa_pkg::TOP_ORDER));
    for (int t = bpa_pkg::TOP_ORDER; t >= 0; t--) begin
      if (64'(req_size) <= (64'd1 << (bpa_pkg::FRAME_SHIFT + t))) tgt = HW'(t);
    end
    found  = 1'b0;
    fo_sel = '0;
    for (int o = bpa_pkg::TOP_ORDER; o >= 0; o--) begin
      if (HW'(o) >= tgt && heads[o] != bpa_pkg::NIL_LINK) begin
        found  = 1'b1;
        fo_sel = HW'(o);
      end
    end
  end

  // Frame index of a freed address, its range check and the buddy indices.
  assign off         = free_address - region_base;
  assign bad_range   = (off >> bpa_pkg::FRAME_SHIFT) >= 32'(bpa_pkg::FRAME_COUNT);
  assign split_buddy = {1'b0, f} + (LW'(1) << (fo - HW'(1)));
  assign merge_buddy = {1'b0, f} ^ (LW'(1) << ord);

  // Store port control for each sequencer step.
  always_comb begin
    ren   = 1'b0;
    wen   = 1'b0;
    raddr = f;
    waddr = f;
    wdata = rdata;
    case (state)
      S_CLEAR: begin
        wen   = 1'b1;
        waddr = clr_idx;
        wdata = bpa_pkg::reset_entry(clr_idx);
      end
      S_SP_RD_F, S_PO_RD_F, S_FR_RD: begin
        ren = 1'b1;
      end
      S_SP_RD_N: begin
        ren   = (rdata.next != bpa_pkg::NIL_LINK);
        raddr = rdata.next[FW-1:0];
      end
      S_SP_WR_N: begin
        wen        = (nlink != bpa_pkg::NIL_LINK);
        waddr      = nlink[FW-1:0];
        wdata.prev = bpa_pkg::NIL_LINK;
        ren        = (head_rd != bpa_pkg::NIL_LINK);
        raddr      = head_rd[FW-1:0];
      end
      S_SP_WR_H: begin
        wen        = (hlink != bpa_pkg::NIL_LINK);
        waddr      = hlink[FW-1:0];
        wdata.prev = {1'b0, buddy};
      end
      S_SP_WR_B: begin
        wen   = 1'b1;
        waddr = buddy;
        wdata = '{alloc: 1'b0, order: bpa_pkg::ORDF_W'(fo - HW'(1)),
                  next: hlink, prev: {1'b0, f}};
      end
      S_SP_WR_F: begin
        wen   = 1'b1;
        wdata = '{alloc: 1'b0, order: bpa_pkg::ORDF_W'(fo - HW'(1)),
                  next: {1'b0, buddy}, prev: bpa_pkg::NIL_LINK};
      end
      S_PO_RD_N: begin
        ren   = (rdata.next != bpa_pkg::NIL_LINK);
        raddr = rdata.next[FW-1:0];
        wen   = 1'b1;
        wdata = '{alloc: 1'b1, order: bpa_pkg::ORDF_W'(target),
                  next: bpa_pkg::NIL_LINK, prev: bpa_pkg::NIL_LINK};
      end
      S_PO_WR_N: begin
        wen        = (nlink != bpa_pkg::NIL_LINK);
        waddr      = nlink[FW-1:0];
        wdata.prev = bpa_pkg::NIL_LINK;
      end
      S_ME_RD_B: begin
        ren   = 1'b1;
        raddr = buddy;
      end
      S_ME_EV: begin
        ren   = !rdata.alloc && rdata.order == bpa_pkg::ORDF_W'(ord) &&
                rdata.prev != bpa_pkg::NIL_LINK;
        raddr = rdata.prev[FW-1:0];
      end
      S_ME_WP: begin
        wen        = (plink != bpa_pkg::NIL_LINK);
        waddr      = plink[FW-1:0];
        wdata.next = nlink;
        ren        = (nlink != bpa_pkg::NIL_LINK);
        raddr      = nlink[FW-1:0];
      end
      S_ME_WN: begin
        wen        = (nlink != bpa_pkg::NIL_LINK);
        waddr      = nlink[FW-1:0];
        wdata.prev = plink;
      end
      S_ME_WL: begin
        wen   = 1'b1;
        waddr = (buddy < f) ? f : buddy;
        wdata = '{alloc: 1'b0, order: bpa_pkg::MERGED_MARK,
                  next: bpa_pkg::NIL_LINK, prev: bpa_pkg::NIL_LINK};
      end
      S_FR_PUSH: begin
        wen   = 1'b1;
        wdata = '{alloc: 1'b0, order: bpa_pkg::ORDF_W'(ord),
                  next: head_rd, prev: bpa_pkg::NIL_LINK};
        ren   = (head_rd != bpa_pkg::NIL_LINK);
        raddr = head_rd[FW-1:0];
      end
      S_FR_WH: begin
        wen        = (hlink != bpa_pkg::NIL_LINK);
        waddr      = hlink[FW-1:0];
        wdata.prev = {1'b0, f};
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  // Frame store with registered read data.
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rdata <= mem[raddr];
  end

  // Sequencer, list heads, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      region_base <= '0;
      out_valid   <= 1'b0;
      for (int o = 0; o <= bpa_pkg::TOP_ORDER; o++) begin
        heads[o] <= (o == bpa_pkg::TOP_ORDER) ?
                    bpa_pkg::NIL_LINK - bpa_pkg::TOP_BLOCK : bpa_pkg::NIL_LINK;
      end
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) region_base <= pwdata;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + FW'(1);
          if (clr_idx == FW'(bpa_pkg::FRAME_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_size   <= alloc_size;
            res_addr   <= '0;
            res_order  <= '0;
            f          <= off[bpa_pkg::FRAME_SHIFT +: FW];
            if (req_type == bpa_pkg::REQ_ALLOC) begin
              state <= S_ALLOC;
            end else if (bad_range) begin
              res_status <= bpa_pkg::STAT_BAD_FREE;
              state      <= S_DONE;
            end else begin
              state <= S_FR_RD;
            end
          end
        end
        S_ALLOC: begin
          target <= tgt;
          fo     <= fo_sel;
          if (too_big) begin
            res_status <= bpa_pkg::STAT_TOO_BIG;
            state      <= S_DONE;
          end else if (!found) begin
            res_status <= bpa_pkg::STAT_NO_BLOCK;
            state      <= S_DONE;
          end else begin
            state <= S_SP_CHK;
          end
        end
        // Split the head of list fo into two halves of the order below.
        S_SP_CHK: begin
          f <= head_rd[FW-1:0];
          if (fo > target) begin
            buddy <= head_rd[FW-1:0] + (FW'(1) << (fo - HW'(1)));
            state <= S_SP_RD_F;
          end else begin
            state <= S_PO_CHK;
          end
        end
        S_SP_RD_F: begin
          if (split_buddy >= bpa_pkg::NIL_LINK) state <= S_PO_CHK;
          else                                  state <= S_SP_RD_N;
        end
        S_SP_RD_N: begin
          nlink <= rdata.next;
          state <= S_SP_WR_N;
        end
        S_SP_WR_N: begin
          hlink <= head_rd;
          state <= S_SP_WR_H;
        end
        S_SP_WR_H: state <= S_SP_WR_B;
        S_SP_WR_B: state <= S_SP_WR_F;
        S_SP_WR_F: begin
          heads[fo]          <= nlink;
          heads[fo - HW'(1)] <= {1'b0, f};
          fo                 <= fo - HW'(1);
          state              <= S_SP_CHK;
        end
        // Pop the head of the target list.
        S_PO_CHK: begin
          f <= head_rd[FW-1:0];
          if (head_rd == bpa_pkg::NIL_LINK) begin
            res_status <= bpa_pkg::STAT_NO_BLOCK;
            state      <= S_DONE;
          end else begin
            state <= S_PO_RD_F;
          end
        end
        S_PO_RD_F: state <= S_PO_RD_N;
        S_PO_RD_N: begin
          nlink         <= rdata.next;
          heads[target] <= rdata.next;
          state         <= S_PO_WR_N;
        end
        S_PO_WR_N: begin
          res_addr   <= region_base + (32'(f) << bpa_pkg::FRAME_SHIFT);
          res_order  <= bpa_pkg::OUT_ORD_W'(target);
          res_status <= bpa_pkg::STAT_OK;
          state      <= S_DONE;
        end
        // Free: check the head, then merge with equal free buddies.
        S_FR_RD: state <= S_FR_CHK;
        S_FR_CHK: begin
          if (!rdata.alloc) begin
            res_status <= bpa_pkg::STAT_BAD_FREE;
            state      <= S_DONE;
          end else begin
            if (rdata.order > bpa_pkg::ORDF_W'(bpa_pkg::TOP_ORDER)) begin
              ord       <= HW'(bpa_pkg::TOP_ORDER);
              first_ord <= HW'(bpa_pkg::TOP_ORDER);
            end else begin
              ord       <= rdata.order[HW-1:0];
              first_ord <= rdata.order[HW-1:0];
            end
            state <= S_ME_CHK;
          end
        end
        S_ME_CHK: begin
          buddy <= merge_buddy[FW-1:0];
          if (ord < HW'(bpa_pkg::TOP_ORDER) && merge_buddy < bpa_pkg::NIL_LINK)
            state <= S_ME_RD_B;
          else
            state <= S_FR_PUSH;
        end
        S_ME_RD_B: state <= S_ME_EV;
        S_ME_EV: begin
          if (rdata.alloc || rdata.order != bpa_pkg::ORDF_W'(ord)) begin
            state <= S_FR_PUSH;
          end else begin
            plink <= rdata.prev;
            nlink <= rdata.next;
            if (rdata.prev == bpa_pkg::NIL_LINK) heads[ord] <= rdata.next;
            state <= S_ME_WP;
          end
        end
        S_ME_WP: state <= S_ME_WN;
        S_ME_WN: state <= S_ME_WL;
        S_ME_WL: begin
          if (buddy < f) f <= buddy;
          ord   <= ord + HW'(1);
          state <= S_ME_CHK;
        end
        S_FR_PUSH: begin
          hlink <= head_rd;
          state <= S_FR_WH;
        end
        S_FR_WH: begin
          heads[ord] <= {1'b0, f};
          res_order  <= bpa_pkg::OUT_ORD_W'(first_ord);
          res_status <= bpa_pkg::STAT_OK;
          state      <= S_DONE;
        end
        // Hand the result word to the output register.
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            block_address <= res_addr;
            block_order   <= res_order;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/bpa_checker.sv
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] block_address,
  input logic [3:0]  block_order,
  input logic [1:0]  status
);

  // A waiting result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_address) && $stable(status))
    else $error("result word changed while stalled");

  // The block is busy on the cycle after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Errors report a zero address and order.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bpa_pkg::STAT_OK |-> block_address == 32'd0 && block_order == 4'd0)
    else $error("error result with non-zero fields");

  // No order beyond the top order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> block_order <= 4'(bpa_pkg::TOP_ORDER))
    else $error("block order out of range");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);

>>> test/tb_top.sv
module tb_top;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  ord;
    logic [1:0]  stat;
  } alloc_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [22:0] alloc_size = '0;
  logic [31:0] free_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] block_address;
  logic [3:0]  block_order;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the frame store and the free lists.
  logic              used_m [FRAME_COUNT];
  logic [ORDF_W-1:0] ord_m  [FRAME_COUNT];
  logic [LINK_W-1:0] nxt_m  [FRAME_COUNT];
  logic [LINK_W-1:0] prv_m  [FRAME_COUNT];
  logic [LINK_W-1:0] head_m [TOP_ORDER+1];
  logic [31:0]       base_m;
  int                last_frame;

  alloc_word_t pending_words[$];
  int          live_frames[$];
  int          err_count = 0;
  int          cyc = 0;
  int          stall_mode = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;

  function automatic void list_push(int o, logic [LINK_W-1:0] f);
    logic [LINK_W-1:0] h;
    h = head_m[o];
    prv_m[f] = NIL_LINK;
    nxt_m[f] = h;
    if (h < NIL_LINK) prv_m[h] = f;
    head_m[o] = f;
  endfunction

  function automatic void list_unlink(int o, logic [LINK_W-1:0] f);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    p = prv_m[f];
    n = nxt_m[f];
    if (p < NIL_LINK) nxt_m[p] = n;
    else head_m[o] = n;
    if (n < NIL_LINK) prv_m[n] = p;
    nxt_m[f] = NIL_LINK;
    prv_m[f] = NIL_LINK;
  endfunction

  function automatic void store_reset();
    int i;
    int o;
    base_m = '0;
    for (int k = 0; k <= TOP_ORDER; k++) head_m[k] = NIL_LINK;
    for (int k = 0; k < FRAME_COUNT; k++) begin
      used_m[k] = 1'b0;
      ord_m[k]  = MERGED_MARK;
      nxt_m[k]  = NIL_LINK;
      prv_m[k]  = NIL_LINK;
    end
    i = 0;
    while (i < FRAME_COUNT) begin
      o = TOP_ORDER;
      while (o > 0 && ((i % (1 << o)) != 0 || i + (1 << o) > FRAME_COUNT)) o--;
      ord_m[i] = ORDF_W'(o);
      list_push(o, LINK_W'(i));
      i += 1 << o;
    end
  endfunction

  // Works out the result word of one request and updates the shadow store.
  function automatic alloc_word_t allocator_outcome(logic rt, logic [22:0] sz,
                                                    logic [31:0] fa);
    alloc_word_t       r;
    int                tgt;
    int                fo;
    int                o;
    logic [LINK_W-1:0] f;
    logic [LINK_W-1:0] bud;
    logic [LINK_W-1:0] lose;
    logic [31:0]       off;
    r = '0;
    last_frame = -1;
    if (rt == REQ_ALLOC) begin
      if (longint'(sz) > (longint'(1) << (FRAME_SHIFT + TOP_ORDER))) begin
        r.stat = STAT_TOO_BIG;
        return r;
      end
      tgt = 0;
      while (tgt < TOP_ORDER && longint'(sz) > (longint'(1) << (FRAME_SHIFT + tgt))) tgt++;
      fo = tgt;
      while (fo <= TOP_ORDER && head_m[fo] >= NIL_LINK) fo++;
      if (fo > TOP_ORDER) begin
        r.stat = STAT_NO_BLOCK;
        return r;
      end
      // Split down to the target order, keeping the lower half.
      while (fo > tgt) begin
        f = head_m[fo];
        bud = f + (LINK_W'(1) << (fo - 1));
        if (bud >= NIL_LINK) break;
        list_unlink(fo, f);
        fo--;
        ord_m[f] = ORDF_W'(fo);
        ord_m[bud] = ORDF_W'(fo);
        list_push(fo, bud);
        list_push(fo, f);
      end
      f = head_m[tgt];
      if (f >= NIL_LINK) begin
        r.stat = STAT_NO_BLOCK;
        return r;
      end
      list_unlink(tgt, f);
      used_m[f] = 1'b1;
      ord_m[f] = ORDF_W'(tgt);
      r.addr = base_m + (32'(f) << FRAME_SHIFT);
      r.ord = 4'(tgt);
      r.stat = STAT_OK;
      last_frame = int'(f);
      return r;
    end
    off = fa - base_m;
    if ((off >> FRAME_SHIFT) >= FRAME_COUNT) begin
      r.stat = STAT_BAD_FREE;
      return r;
    end
    f = LINK_W'(off >> FRAME_SHIFT);
    if (!used_m[f]) begin
      r.stat = STAT_BAD_FREE;
      return r;
    end
    o = int'(ord_m[f]);
    if (o > TOP_ORDER) o = TOP_ORDER;
    used_m[f] = 1'b0;
    r.ord = 4'(o);
    r.stat = STAT_OK;
    last_frame = int'(f);
    // Merge with free buddies of the same order.
    while (o < TOP_ORDER) begin
      bud = f ^ (LINK_W'(1) << o);
      if (bud >= NIL_LINK || used_m[bud] || ord_m[bud] != ORDF_W'(o)) break;
      list_unlink(o, bud);
      if (bud < f) begin
        lose = f;
        f = bud;
      end else begin
        lose = bud;
      end
      o++;
      ord_m[f] = ORDF_W'(o);
      ord_m[lose] = MERGED_MARK;
    end
    ord_m[f] = ORDF_W'(o);
    list_push(o, f);
    return r;
  endfunction

  // Receiver stall pattern and the run limit.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ((cyc % 53) >= 20);
      end
    endcase
    if (cyc >= CYCLE_LIMIT) begin
      $display("[buddy_page_allocator_unit] ERROR");
      $finish;
    end
  end

  // Checks each accepted result word against the oldest expected word.
  always @(negedge clk) begin
    alloc_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN) $display("unexpected result word at cycle %0d", cyc);
      end else begin
        want = pending_words.pop_front();
        if (block_address !== want.addr || block_order !== want.ord ||
            status !== want.stat) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("mismatch: expected addr %h order %0d status %0d, got %h %0d %0d",
                     want.addr, want.ord, want.stat, block_address, block_order, status);
        end
      end
    end
  end

  // Sends one request word; called at a rising edge, returns at its acceptance edge.
  task automatic send_word(logic rt, logic [22:0] sz, logic [31:0] fa);
    alloc_word_t r;
    if (burst_left == 0) begin
      if (!no_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= rt;
    alloc_size <= sz;
    free_address <= fa;
    forever begin
      @(negedge clk);
      if (in_ready) begin
        r = allocator_outcome(rt, sz, fa);
        pending_words.push_back(r);
        if (r.stat == STAT_OK) begin
          if (rt == REQ_ALLOC) live_frames.push_back(last_frame);
          else
            foreach (live_frames[i])
              if (live_frames[i] == last_frame) begin
                live_frames.delete(i);
                break;
              end
        end
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic alloc_word(logic [22:0] sz);
    send_word(REQ_ALLOC, sz, '0);
  endtask

  task automatic free_frame(int f, logic [11:0] off);
    send_word(!REQ_ALLOC, '0, base_m + (32'(f) << FRAME_SHIFT) + 32'(off));
  endtask

  // Lets every outstanding word drain, then leaves the block idle a while.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    base_m = v;
    @(posedge clk);
  endtask

  // Frees everything still held so that a phase starts from the reset layout.
  task automatic release_all();
    while (live_frames.size() != 0) free_frame(live_frames[0], '0);
  endtask

  // Sizes at the order boundaries, the size limit and the zero size.
  task automatic test_sizes();
    logic [22:0] sizes[9];
    sizes = '{23'd0, 23'd1, 23'd4096, 23'd4097, 23'd8192, 23'h200001,
              23'h400000, 23'h400001, 23'h7fffff};
    foreach (sizes[i]) alloc_word(sizes[i]);
    release_all();
  endtask

  // Exhausts the region, then asks again for both a large and a small block.
  task automatic test_exhaustion();
    repeat (5) alloc_word(23'h400000);
    alloc_word(23'd0);
    release_all();
  endtask

  // Frees of addresses that do not name an allocated block head, and one that does with a page offset.
  task automatic test_bad_frees();
    alloc_word(23'd8192);
    free_frame(live_frames[0] + 1, 12'h0);
    free_frame(100, 12'h0);
    free_frame(FRAME_COUNT, 12'h0);
    send_word(!REQ_ALLOC, '0, base_m - 32'd1);
    send_word(!REQ_ALLOC, '0, 32'hffffffff);
    free_frame(live_frames[0], 12'hfff);
    free_frame(0, 12'h0);
  endtask

  // Random mix of mostly well-formed allocations and frees, with some noise.
  task automatic test_random(int count);
    int          pick;
    int          o;
    int          idx;
    logic [22:0] sz;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick < 90 && live_frames.size() == 0)) begin
        o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TOP_ORDER) : $urandom_range(0, 3);
        if (o == 0) sz = 23'($urandom_range(0, 4096));
        else sz = 23'($urandom_range((1 << (FRAME_SHIFT + o - 1)) + 1, 1 << (FRAME_SHIFT + o)));
        alloc_word(sz);
      end else if (pick < 90) begin
        idx = $urandom_range(0, live_frames.size() - 1);
        free_frame(live_frames[idx], 12'($urandom));
      end else if (pick < 95) begin
        alloc_word(23'($urandom_range(23'h400000, 23'h7fffff)));
      end else begin
        send_word(!REQ_ALLOC, '0, $urandom);
      end
    end
  endtask

  initial begin
    store_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_base(32'h0);
    test_sizes();
    test_exhaustion();
    test_bad_frees();
    wait_idle();

    // Highest page-aligned base, so that block addresses wrap around.
    write_base(32'hfffff000);
    stall_mode = 1;
    test_random(110);
    wait_idle();

    write_base($urandom);
    stall_mode = 2;
    test_random(110);
    release_all();
    wait_idle();

    write_base(32'hffffffff);
    stall_mode = 0;
    no_gaps = 1'b1;
    test_random(80);
    wait_idle();

    write_base(32'h0);
    no_gaps = 1'b0;
    stall_mode = 1;
    test_random(110);
    wait_idle();

    if (err_count == 0) begin
      $display("[buddy_page_allocator_unit] OK");
    end else begin
      $display("[buddy_page_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
